FILE: rtl/quantum_annealing_spin_update_defines.svh
// Assertion macros shared by the checker of the spin update block.
// No dependencies; include by bare file name.
`ifndef QUANTUM_ANNEALING_SPIN_UPDATE_DEFINES_SVH
`define QUANTUM_ANNEALING_SPIN_UPDATE_DEFINES_SVH

// same-cycle implication
`define QASU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qasu assertion failed");

// next-cycle implication
`define QASU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qasu assertion failed");

`endif

FILE: rtl/qasu_pkg.sv
// Shared codes, types and the 2^-x table of the spin update block.
// No dependencies.
package qasu_pkg;

  localparam logic [2:0] MODE_WR_COUPLING = 3'd0;
  localparam logic [2:0] MODE_WR_BIAS     = 3'd1;
  localparam logic [2:0] MODE_WR_SPIN     = 3'd2;
  localparam logic [2:0] MODE_FLIP        = 3'd3;
  localparam logic [2:0] MODE_RD_SPIN     = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SPINS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLICAS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA     = 3'd4;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef enum logic [4:0] {
    OP_NONE, OP_WRITE, OP_RD_SELF, OP_RD_START, OP_ROW, OP_RD_NA, OP_RD_NB,
    OP_MUL_CL, OP_DE, OP_MUL_A0, OP_MUL_A1, OP_A_SUM, OP_MUL_E0, OP_MUL_E1,
    OP_E_SUM, OP_MUL_T, OP_DECIDE, OP_FLIP_WR
  } op_e;

  typedef struct packed {
    logic take;
    logic present;
    op_e  op;
  } ctl_cmd_t;

  typedef struct packed {
    logic flip_ok;
    logic row_last;
  } dp_stat_t;

  // round(2^(-i/16) * 65536)
  function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
    logic [16:0] t;
    case (idx)
      5'd0:  t = 17'd65536;
      5'd1:  t = 17'd62757;
      5'd2:  t = 17'd60097;
      5'd3:  t = 17'd57549;
      5'd4:  t = 17'd55109;
      5'd5:  t = 17'd52773;
      5'd6:  t = 17'd50535;
      5'd7:  t = 17'd48393;
      5'd8:  t = 17'd46341;
      5'd9:  t = 17'd44376;
      5'd10: t = 17'd42495;
      5'd11: t = 17'd40693;
      5'd12: t = 17'd38968;
      5'd13: t = 17'd37316;
      5'd14: t = 17'd35734;
      5'd15: t = 17'd34219;
      default: t = 17'd32768;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/qasu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module qasu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/qasu_ctrl.sv
// Controller of the spin update block: sequences item load, stores, row walk
// and acceptance math. Uses qasu_pkg.
module qasu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  qasu_pkg::dp_stat_t  stat_i,
  output qasu_pkg::ctl_cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_EXEC  = 5'd1;
  localparam logic [4:0] S_READ  = 5'd2;
  localparam logic [4:0] S_WAIT  = 5'd3;
  localparam logic [4:0] S_START = 5'd4;
  localparam logic [4:0] S_ROW   = 5'd5;
  localparam logic [4:0] S_NA    = 5'd6;
  localparam logic [4:0] S_NB    = 5'd7;
  localparam logic [4:0] S_MCL   = 5'd8;
  localparam logic [4:0] S_DE    = 5'd9;
  localparam logic [4:0] S_A0    = 5'd10;
  localparam logic [4:0] S_A1    = 5'd11;
  localparam logic [4:0] S_ASUM  = 5'd12;
  localparam logic [4:0] S_E0    = 5'd13;
  localparam logic [4:0] S_E1    = 5'd14;
  localparam logic [4:0] S_ESUM  = 5'd15;
  localparam logic [4:0] S_MT    = 5'd16;
  localparam logic [4:0] S_DEC   = 5'd17;
  localparam logic [4:0] S_FWR   = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0] state_q, state_d;
  logic       valid_q, valid_d;
  logic       out_free;

  assign out_free   = !valid_q || m_tready_i;
  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.take    = 1'b0;
    cmd_o.present = 1'b0;
    cmd_o.op      = qasu_pkg::OP_NONE;
    valid_d       = valid_q && !m_tready_i;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.op = qasu_pkg::OP_WRITE;
        state_d  = stat_i.flip_ok ? S_START : S_READ;
      end
      S_READ: begin
        cmd_o.op = qasu_pkg::OP_RD_SELF;
        state_d  = S_WAIT;
      end
      S_WAIT:  state_d = S_OUT;
      S_START: begin
        cmd_o.op = qasu_pkg::OP_RD_START;
        state_d  = S_ROW;
      end
      S_ROW: begin
        cmd_o.op = qasu_pkg::OP_ROW;
        if (stat_i.row_last) begin
          state_d = S_NA;
        end
      end
      S_NA: begin
        cmd_o.op = qasu_pkg::OP_RD_NA;
        state_d  = S_NB;
      end
      S_NB: begin
        cmd_o.op = qasu_pkg::OP_RD_NB;
        state_d  = S_MCL;
      end
      S_MCL: begin
        cmd_o.op = qasu_pkg::OP_MUL_CL;
        state_d  = S_DE;
      end
      S_DE: begin
        cmd_o.op = qasu_pkg::OP_DE;
        state_d  = S_A0;
      end
      S_A0: begin
        cmd_o.op = qasu_pkg::OP_MUL_A0;
        state_d  = S_A1;
      end
      S_A1: begin
        cmd_o.op = qasu_pkg::OP_MUL_A1;
        state_d  = S_ASUM;
      end
      S_ASUM: begin
        cmd_o.op = qasu_pkg::OP_A_SUM;
        state_d  = S_E0;
      end
      S_E0: begin
        cmd_o.op = qasu_pkg::OP_MUL_E0;
        state_d  = S_E1;
      end
      S_E1: begin
        cmd_o.op = qasu_pkg::OP_MUL_E1;
        state_d  = S_ESUM;
      end
      S_ESUM: begin
        cmd_o.op = qasu_pkg::OP_E_SUM;
        state_d  = S_MT;
      end
      S_MT: begin
        cmd_o.op = qasu_pkg::OP_MUL_T;
        state_d  = S_DEC;
      end
      S_DEC: begin
        cmd_o.op = qasu_pkg::OP_DECIDE;
        state_d  = S_FWR;
      end
      S_FWR: begin
        cmd_o.op = qasu_pkg::OP_FLIP_WR;
        state_d  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.present = 1'b1;
          valid_d       = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

endmodule

FILE: rtl/qasu_datapath.sv
// Datapath of the spin update block: config registers, stores, row
// accumulator, shared multiplier and acceptance logic. Uses qasu_pkg, qasu_ram.
module qasu_datapath #(
  parameter int MAX_SPINS    = 256,
  parameter int MAX_REPLICAS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [qasu_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [qasu_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [2:0]                         mode_i,
  input  logic [5:0]                         replica_i,
  input  logic [7:0]                         spin_index_i,
  input  logic [7:0]                         partner_index_i,
  input  logic signed [15:0]                 value_i,
  input  logic [15:0]                        rand_u_i,
  input  qasu_pkg::ctl_cmd_t                 cmd_i,
  output qasu_pkg::dp_stat_t                 stat_o,
  output logic                               spin_up_o,
  output logic                               flipped_o,
  output logic signed [31:0]                 delta_energy_o
);

  localparam int SW    = $clog2(MAX_SPINS);
  localparam int RW    = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  localparam int NW    = SW + 1;
  localparam int MW    = RW + 1;
  localparam int ACC_W = 17 + SW;
  localparam int MA_W  = (ACC_W > 25) ? ACC_W : 25;
  localparam int MB_W  = 25;
  localparam int P_W   = MA_W + MB_W;
  localparam int DE_W  = (((ACC_W + 8) > 35) ? (ACC_W + 8) : 35) + 1;
  localparam logic signed [DE_W-1:0] DE_MAX = DE_W'(2147483647);
  localparam logic signed [DE_W-1:0] DE_MIN = ~DE_MAX;

  // configuration
  logic [8:0]         spins_q;
  logic [6:0]         replicas_q;
  logic [15:0]        weight_q;
  logic signed [31:0] coupling_q;
  logic [23:0]        beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spins_q    <= 9'd256;
      replicas_q <= 7'd64;
      weight_q   <= 16'd512;
      coupling_q <= '0;
      beta_q     <= 24'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        qasu_pkg::CFG_SPINS:    spins_q    <= cfg_wdata_i[8:0];
        qasu_pkg::CFG_REPLICAS: replicas_q <= cfg_wdata_i[6:0];
        qasu_pkg::CFG_WEIGHT:   weight_q   <= cfg_wdata_i[15:0];
        qasu_pkg::CFG_COUPLING: coupling_q <= $signed(cfg_wdata_i);
        qasu_pkg::CFG_BETA:     beta_q     <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [2:0]         mode_q;
  logic [5:0]         y_q;
  logic [7:0]         x_q;
  logic [7:0]         p_q;
  logic signed [15:0] val_q;
  logic [15:0]        u_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q <= mode_i;
      y_q    <= replica_i;
      x_q    <= spin_index_i;
      p_q    <= partner_index_i;
      val_q  <= value_i;
      u_q    <= rand_u_i;
    end
  end

  logic [NW-1:0] n_eff;
  logic [MW-1:0] m_eff;
  logic [SW-1:0] xs, ps;
  logic [RW-1:0] ys, ya, yb;
  logic          xok, pok, yok;

  always_comb begin
    if (spins_q == '0) n_eff = NW'(1);
    else if (32'(spins_q) > MAX_SPINS) n_eff = NW'(MAX_SPINS);
    else n_eff = NW'(spins_q);
    if (replicas_q == '0) m_eff = MW'(1);
    else if (32'(replicas_q) > MAX_REPLICAS) m_eff = MW'(MAX_REPLICAS);
    else m_eff = MW'(replicas_q);
  end

  assign xs  = SW'(x_q);
  assign ps  = SW'(p_q);
  assign ys  = RW'(y_q);
  assign xok = 32'(x_q) < MAX_SPINS;
  assign pok = 32'(p_q) < MAX_SPINS;
  assign yok = 32'(y_q) < MAX_REPLICAS;
  // neighbours wrap around the active replicas
  assign ya  = (ys == '0) ? RW'(m_eff - MW'(1)) : ys - RW'(1);
  assign yb  = (MW'(ys) == m_eff - MW'(1)) ? '0 : ys + RW'(1);

  logic [SW-1:0] j_q;
  qasu_pkg::op_e op_q;

  assign stat_o.flip_ok  = (mode_q == qasu_pkg::MODE_FLIP) && xok && yok
                           && (NW'(xs) < n_eff) && (MW'(ys) < m_eff);
  assign stat_o.row_last = (j_q == SW'(n_eff - NW'(1)));

  // stores
  logic               coup_we, bias_we, spin_we;
  logic               spin_wd;
  logic [RW+SW-1:0]   spin_ra;
  logic signed [15:0] coup_rd, bias_rd;
  logic               spin_rd;
  logic               flip_q, q_q, qa_q, qb_q;

  assign coup_we = (cmd_i.op == qasu_pkg::OP_WRITE) && (mode_q == qasu_pkg::MODE_WR_COUPLING)
                   && xok && pok;
  assign bias_we = (cmd_i.op == qasu_pkg::OP_WRITE) && (mode_q == qasu_pkg::MODE_WR_BIAS) && xok;

  always_comb begin
    spin_we = 1'b0;
    spin_wd = val_q[0];
    spin_ra = {ys, xs};
    case (cmd_i.op)
      qasu_pkg::OP_WRITE: begin
        spin_we = (mode_q == qasu_pkg::MODE_WR_SPIN) && xok && yok;
      end
      qasu_pkg::OP_FLIP_WR: begin
        spin_we = flip_q;
        spin_wd = !q_q;
      end
      qasu_pkg::OP_ROW:   spin_ra = {ys, j_q};
      qasu_pkg::OP_RD_NA: spin_ra = {ya, xs};
      qasu_pkg::OP_RD_NB: spin_ra = {yb, xs};
      default: ;
    endcase
  end

  qasu_ram #(.WIDTH(16), .DEPTH(1 << (2 * SW))) u_coup_ram (
    .clk_i   (clk_i),
    .we_i    (coup_we),
    .waddr_i ({xs, ps}),
    .wdata_i (val_q),
    .raddr_i ({xs, j_q}),
    .rdata_o (coup_rd)
  );

  qasu_ram #(.WIDTH(16), .DEPTH(1 << SW)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (bias_we),
    .waddr_i (xs),
    .wdata_i (val_q),
    .raddr_i (xs),
    .rdata_o (bias_rd)
  );

  qasu_ram #(.WIDTH(1), .DEPTH(1 << (RW + SW))) u_spin_ram (
    .clk_i   (clk_i),
    .we_i    (spin_we),
    .waddr_i ({ys, xs}),
    .wdata_i (spin_wd),
    .raddr_i (spin_ra),
    .rdata_o (spin_rd)
  );

  // arithmetic
  logic signed [ACC_W-1:0] acc_q;
  logic signed [MA_W-1:0]  ma;
  logic signed [MB_W-1:0]  mb;
  logic signed [P_W-1:0]   prod_q, prod_s, cl_full;
  logic signed [DE_W-1:0]  c2, qterm, de_d;
  logic [31:0]             sat_d, sat_q;
  logic                    neg_q;
  logic [39:0]             a0_q;
  logic [38:0]             a_q;
  logic [36:0]             e0_q;
  logic [55:0]             e_full;
  logic [55:0]             e_q;
  logic [3:0]              t_idx;
  logic [16:0]             t_lo, t_hi, t_diff, v, t_val;
  logic                    spin_up_q, flipped_q;
  logic signed [31:0]      delta_q;

  assign t_idx  = e_q[15:12];
  assign t_lo   = qasu_pkg::pow2_tab({1'b0, t_idx});
  assign t_hi   = qasu_pkg::pow2_tab({1'b0, t_idx} + 5'd1);
  assign t_diff = t_lo - t_hi;
  assign v      = t_lo - {5'd0, prod_q[23:12]};
  assign t_val  = (e_q[55:16] > 40'd16) ? 17'd0 : (v >> e_q[20:16]);

  // a * log2(e) in full, the exponent keeps its upper bits
  assign e_full = {prod_q[35:0], 20'd0} + 56'(e0_q);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      qasu_pkg::OP_MUL_CL: begin
        ma = MA_W'(acc_q);
        mb = $signed(MB_W'(weight_q));
      end
      qasu_pkg::OP_MUL_A0: begin
        ma = $signed(MA_W'(sat_q[15:0]));
        mb = $signed(MB_W'(beta_q));
      end
      qasu_pkg::OP_MUL_A1: begin
        ma = $signed(MA_W'(sat_q[30:16]));
        mb = $signed(MB_W'(beta_q));
      end
      qasu_pkg::OP_MUL_E0: begin
        ma = $signed(MA_W'(a_q[19:0]));
        mb = $signed(MB_W'(qasu_pkg::LOG2E_Q16));
      end
      qasu_pkg::OP_MUL_E1: begin
        ma = $signed(MA_W'(a_q[38:20]));
        mb = $signed(MB_W'(qasu_pkg::LOG2E_Q16));
      end
      qasu_pkg::OP_MUL_T: begin
        ma = $signed(MA_W'(t_diff));
        mb = $signed(MB_W'(e_q[11:0]));
      end
      default: ;
    endcase
  end

  // classical term is -q*w*acc, floored to Q16.16
  assign prod_s  = q_q ? -prod_q : prod_q;
  assign cl_full = prod_s >>> 10;
  assign c2      = DE_W'(coupling_q) <<< 1;
  assign qterm   = (qa_q != qb_q) ? '0 : ((qa_q == q_q) ? c2 : -c2);
  assign de_d    = $signed(cl_full[DE_W-1:0]) - qterm;

  always_comb begin
    if (de_d > DE_MAX) sat_d = 32'h7fff_ffff;
    else if (de_d < DE_MIN) sat_d = 32'h8000_0000;
    else sat_d = de_d[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= qasu_pkg::OP_NONE;
      j_q  <= '0;
    end else begin
      op_q <= cmd_i.op;
      if (cmd_i.op == qasu_pkg::OP_RD_START) begin
        j_q <= '0;
      end else if (cmd_i.op == qasu_pkg::OP_ROW) begin
        j_q <= j_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= P_W'(ma) * P_W'(mb);
    // consume read data of the op issued last cycle
    case (op_q)
      qasu_pkg::OP_RD_SELF:  spin_up_q <= xok && yok && spin_rd;
      qasu_pkg::OP_RD_START: begin
        q_q   <= spin_rd;
        acc_q <= ACC_W'(bias_rd);
      end
      qasu_pkg::OP_ROW: begin
        acc_q <= spin_rd ? acc_q + ACC_W'(coup_rd) : acc_q - ACC_W'(coup_rd);
      end
      qasu_pkg::OP_RD_NA: qa_q <= spin_rd;
      qasu_pkg::OP_RD_NB: qb_q <= spin_rd;
      default: ;
    endcase
    case (cmd_i.op)
      qasu_pkg::OP_WRITE: begin
        flipped_q <= 1'b0;
        delta_q   <= '0;
      end
      qasu_pkg::OP_DE: begin
        sat_q   <= sat_d;
        neg_q   <= de_d[DE_W-1];
        delta_q <= $signed(sat_d);
      end
      qasu_pkg::OP_MUL_A1: a0_q <= prod_q[39:0];
      qasu_pkg::OP_A_SUM:  a_q  <= prod_q[38:0] + 39'(a0_q[39:16]);
      qasu_pkg::OP_MUL_E1: e0_q <= prod_q[36:0];
      qasu_pkg::OP_E_SUM:  e_q  <= {16'd0, e_full[55:16]};
      qasu_pkg::OP_DECIDE: flip_q <= neg_q || (t_val > {1'b0, u_q});
      qasu_pkg::OP_FLIP_WR: begin
        spin_up_q <= flip_q ? !q_q : q_q;
        flipped_q <= flip_q;
      end
      default: ;
    endcase
  end

  // output register, loaded when the result is presented
  always_ff @(posedge clk_i) begin
    if (cmd_i.present) begin
      spin_up_o      <= spin_up_q;
      flipped_o      <= flipped_q;
      delta_energy_o <= delta_q;
    end
  end

endmodule

FILE: rtl/quantum_annealing_spin_update.sv
// Top level of the dense Ising path-integral spin update block.
// Depends on qasu_pkg, qasu_ctrl, qasu_datapath (and qasu_ram below it).
//
// Usage: items arrive on the s_axis word channel (mode in tuser), one result
// word leaves on m_axis for every item. Configuration is written through the
// cfg_we_i / cfg_addr_i / cfg_wdata_i port while the block is idle.
// Items are handled one at a time. A store write or spin read passes the
// execute, read and wait states before its result is presented; a flip attempt
// walks the coupling row of the N active spins through the single coupling
// RAM read port, one entry a cycle, and the acceptance math after it runs six
// multiplies on one shared multiplier.
// A new item is taken as soon as the previous result sits in the output
// register; the result stays there, unchanged, until m_axis_tready takes it,
// and the next result waits in the datapath while it is stalled.
// Reset returns the configuration registers to their defaults and empties the
// output register; the coupling, bias and spin stores hold no defined content
// until written.
module quantum_annealing_spin_update #(
  parameter int MAX_SPINS    = 256,
  parameter int MAX_REPLICAS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // replica[5:0], spin_index[13:6], partner_index[21:14], value[37:22],
  // rand_u[53:38], zero pad
  input  logic [qasu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // spin_up[0], flipped[1], delta_energy[33:2], zero pad
  output logic [qasu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [qasu_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [qasu_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  qasu_pkg::ctl_cmd_t cmd;
  qasu_pkg::dp_stat_t stat;
  logic               spin_up, flipped;
  logic signed [31:0] delta_energy;

  qasu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  qasu_datapath #(
    .MAX_SPINS    (MAX_SPINS),
    .MAX_REPLICAS (MAX_REPLICAS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mode_i          (s_axis_tuser),
    .replica_i       (s_axis_tdata[5:0]),
    .spin_index_i    (s_axis_tdata[13:6]),
    .partner_index_i (s_axis_tdata[21:14]),
    .value_i         ($signed(s_axis_tdata[37:22])),
    .rand_u_i        (s_axis_tdata[53:38]),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .spin_up_o       (spin_up),
    .flipped_o       (flipped),
    .delta_energy_o  (delta_energy)
  );

  assign m_axis_tdata = {6'd0, delta_energy, flipped, spin_up};

endmodule

FILE: rtl/qasu_checker.sv
// Port-level checker for the spin update block, bound to the top level.
// Depends on qasu_pkg and quantum_annealing_spin_update_defines.svh.
`include "quantum_annealing_spin_update_defines.svh"

module qasu_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [qasu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result word must not move
  `QASU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // a negative energy change is always taken
  `QASU_ASSERT_IMPL(a_neg_flips, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[33], m_axis_tdata[1])

  // one item at a time: the input closes right after a word is taken
  `QASU_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind quantum_annealing_spin_update qasu_checker u_qasu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
